FILE: hdl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and codes of the page frame bitmap allocator: request and
// response words, the job word passed from the front end to the engine.
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int PAGE_W   = 16;
   localparam int CNT_W    = 17;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;
   localparam int OFF_W    = 6;
   localparam int WIDX_W   = 17;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
   localparam logic [OP_W-1:0] OP_LOCK      = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
   localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
   localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;
   localparam logic [OP_W-1:0] OP_REQUEST   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [PAGE_W-1:0] first_page;
      logic [CNT_W-1:0]  page_count;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] granted_page;
      logic [CNT_W-1:0]  pages_changed;
      logic [CNT_W-1:0]  free_pages;
      logic [CNT_W-1:0]  used_pages;
      logic [CNT_W-1:0]  reserved_pages;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic              empty;
      logic [STAT_W-1:0] status;
      logic [WIDX_W-1:0] first_word;
      logic [OFF_W-1:0]  first_off;
      logic [WIDX_W-1:0] last_word;
      logic [OFF_W-1:0]  last_off;
   } job_type;

endpackage

FILE: hdl/pfba_front.sv
// ----------------------------------------------------------------------------
// pfba_front
// Accepts request words, clips the page run to the managed size, sets the
// early status and turns the run into first/last map word and bit offsets.
// ----------------------------------------------------------------------------
module pfba_front #(
   parameter int MAX_PAGES     = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pfba_pkg::req_type        req_data,
   input  logic [pfba_pkg::CNT_W-1:0] size,
   output logic                     job_push,
   input  logic                     job_full,
   output pfba_pkg::job_type        job_data
);

   localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int SH        = pfba_pkg::CNT_W + $clog2(MAP_WORD_BITS) + 1;
   localparam longint RECIP = ((longint'(1) << SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int RW        = $clog2(RECIP + 1);
   localparam int PW        = pfba_pkg::CNT_W + RW;

   logic                         s1_valid_ff, s2_valid_ff;
   logic                         en1, en2;
   logic [pfba_pkg::OP_W-1:0]    s1_op_ff, s1_op_in, s2_op_ff;
   logic                         s1_empty_ff, s1_empty_in, s2_empty_ff;
   logic [pfba_pkg::STAT_W-1:0]  s1_status_ff, s1_status_in, s2_status_ff;
   logic [pfba_pkg::CNT_W-1:0]   s1_lo_ff, s1_lo_in, s1_hi_ff, s1_hi_in;
   logic [pfba_pkg::CNT_W-1:0]   s2_lo_ff, s2_hi_ff;
   logic [pfba_pkg::CNT_W-1:0]   s2_lo_q_ff, s2_lo_q_in, s2_hi_q_ff, s2_hi_q_in;
   logic [pfba_pkg::CNT_W:0]     run_sum;
   logic [pfba_pkg::CNT_W-1:0]   run_end;
   logic [PW-1:0]                lo_prod, hi_prod;
   logic [pfba_pkg::CNT_W-1:0]   lo_rem, hi_rem;

   assign job_push  = s2_valid_ff && !job_full;
   assign en2       = !s2_valid_ff || job_push;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   // run end clipped to the managed size
   assign run_sum = (pfba_pkg::CNT_W+1)'(req_data.first_page)
                  + (pfba_pkg::CNT_W+1)'(req_data.page_count);
   assign run_end = (run_sum > (pfba_pkg::CNT_W+1)'(size)) ? size
                                                           : run_sum[pfba_pkg::CNT_W-1:0];

   always_comb begin
      s1_op_in     = req_data.opcode;
      s1_empty_in  = 1'b1;
      s1_status_in = pfba_pkg::STAT_OK;
      s1_lo_in     = '0;
      s1_hi_in     = '0;
      case (req_data.opcode)
         pfba_pkg::OP_INIT: begin
            s1_empty_in = 1'b0;
         end
         pfba_pkg::OP_LOCK, pfba_pkg::OP_FREE,
         pfba_pkg::OP_RESERVE, pfba_pkg::OP_UNRESERVE: begin
            s1_empty_in  = (req_data.page_count == '0)
                        || (pfba_pkg::CNT_W'(req_data.first_page) >= size);
            s1_status_in = ((req_data.page_count != '0)
                           && (run_sum > (pfba_pkg::CNT_W+1)'(size)))
                         ? pfba_pkg::STAT_RANGE : pfba_pkg::STAT_OK;
            s1_lo_in     = pfba_pkg::CNT_W'(req_data.first_page);
            s1_hi_in     = run_end - pfba_pkg::CNT_W'(1);
         end
         pfba_pkg::OP_REQUEST: begin
            s1_empty_in  = (size <= pfba_pkg::CNT_W'(1));
            s1_status_in = (size <= pfba_pkg::CNT_W'(1)) ? pfba_pkg::STAT_NOFREE
                                                         : pfba_pkg::STAT_OK;
            s1_lo_in     = pfba_pkg::CNT_W'(1);
            s1_hi_in     = size - pfba_pkg::CNT_W'(1);
         end
         default: begin
            s1_empty_in = 1'b1;
         end
      endcase
   end

   // word index by reciprocal multiply
   assign lo_prod    = PW'(s1_lo_ff) * PW'(RECIP);
   assign hi_prod    = PW'(s1_hi_ff) * PW'(RECIP);
   assign s2_lo_q_in = pfba_pkg::CNT_W'(lo_prod >> SH);
   assign s2_hi_q_in = pfba_pkg::CNT_W'(hi_prod >> SH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff     <= s1_op_in;
         s1_empty_ff  <= s1_empty_in;
         s1_status_ff <= s1_status_in;
         s1_lo_ff     <= s1_lo_in;
         s1_hi_ff     <= s1_hi_in;
      end
      if (en2) begin
         s2_op_ff     <= s1_op_ff;
         s2_empty_ff  <= s1_empty_ff;
         s2_status_ff <= s1_status_ff;
         s2_lo_ff     <= s1_lo_ff;
         s2_hi_ff     <= s1_hi_ff;
         s2_lo_q_ff   <= s2_lo_q_in;
         s2_hi_q_ff   <= s2_hi_q_in;
      end
   end

   assign lo_rem = s2_lo_ff - pfba_pkg::CNT_W'(s2_lo_q_ff * pfba_pkg::CNT_W'(MAP_WORD_BITS));
   assign hi_rem = s2_hi_ff - pfba_pkg::CNT_W'(s2_hi_q_ff * pfba_pkg::CNT_W'(MAP_WORD_BITS));

   always_comb begin
      job_data.opcode     = s2_op_ff;
      job_data.empty      = s2_empty_ff;
      job_data.status     = s2_status_ff;
      job_data.first_word = pfba_pkg::WIDX_W'(s2_lo_q_ff);
      job_data.first_off  = pfba_pkg::OFF_W'(lo_rem);
      job_data.last_word  = pfba_pkg::WIDX_W'(s2_hi_q_ff);
      job_data.last_off   = pfba_pkg::OFF_W'(hi_rem);
      if (s2_empty_ff) begin
         job_data.first_word = '0;
         job_data.first_off  = '0;
         job_data.last_word  = '0;
         job_data.last_off   = '0;
      end else if (s2_op_ff == pfba_pkg::OP_INIT) begin
         job_data.first_word = '0;
         job_data.first_off  = '0;
         job_data.last_word  = pfba_pkg::WIDX_W'(MAP_WORDS - 1);
         job_data.last_off   = pfba_pkg::OFF_W'(MAP_WORD_BITS - 1);
      end
   end

endmodule

FILE: hdl/pfba_queue.sv
// ----------------------------------------------------------------------------
// pfba_queue
// Short job queue between the front end and the map engine.
// ----------------------------------------------------------------------------
module pfba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfba_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output pfba_pkg::job_type pop_data,
   output logic              not_empty
);

   localparam int DEPTH = pfba_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfba_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/pfba_back.sv
// ----------------------------------------------------------------------------
// pfba_back
// Map engine: holds the page bitmap memory and the page counters, walks the
// map word by word with read-modify-write and drives the response register.
// ----------------------------------------------------------------------------
module pfba_back #(
   parameter int MAX_PAGES     = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  pfba_pkg::job_type          job_data,
   output logic                       job_pop,
   input  logic [pfba_pkg::CNT_W-1:0] size,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pfba_pkg::rsp_type          rsp_data
);

   localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = $clog2(MAP_WORD_BITS);
   localparam int NW        = $clog2(MAP_WORD_BITS + 1);
   localparam int PIW       = WAW + BW + 1;
   localparam logic [pfba_pkg::CNT_W-1:0] FREE_RESET =
      pfba_pkg::CNT_W'((MAX_PAGES < 65536) ? MAX_PAGES : 65536);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [MAP_WORD_BITS-1:0]     map_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0]     rd_data_ff;
   logic [WAW-1:0]               rd_addr, wr_addr;
   logic [MAP_WORD_BITS-1:0]     wr_data;
   logic                         wr_en;

   logic [2:0]                   state_ff, state_in;
   logic [WAW-1:0]               word_ff, word_in, clr_ff, clr_in;
   pfba_pkg::job_type            cur_ff, cur_in;
   logic [pfba_pkg::CNT_W-1:0]   changed_ff, changed_in;
   logic [pfba_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [pfba_pkg::PAGE_W-1:0]  granted_ff, granted_in;
   logic [pfba_pkg::CNT_W-1:0]   free_ff, free_in, used_ff, used_in, res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pfba_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         slot_free, start;
   logic                         is_first, is_last, done, found, req_op;
   logic [MAP_WORD_BITS-1:0]     mask, cand, low, change, new_word;
   logic [NW-1:0]                n_changed;
   logic [BW-1:0]                low_idx;
   logic [PIW-1:0]               page_idx;

   function automatic logic [pfba_pkg::CNT_W-1:0] sat_add(
      input logic [pfba_pkg::CNT_W-1:0] a, input logic [NW-1:0] b);
      logic [pfba_pkg::CNT_W:0] s;
      s = (pfba_pkg::CNT_W+1)'(a) + (pfba_pkg::CNT_W+1)'(b);
      return s[pfba_pkg::CNT_W] ? pfba_pkg::CNT_MAX : s[pfba_pkg::CNT_W-1:0];
   endfunction

   function automatic logic [pfba_pkg::CNT_W-1:0] sat_sub(
      input logic [pfba_pkg::CNT_W-1:0] a, input logic [NW-1:0] b);
      logic [pfba_pkg::CNT_W-1:0] bx;
      bx = pfba_pkg::CNT_W'(b);
      return (a < bx) ? '0 : a - bx;
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign start     = job_valid
                   && ((state_ff == S_IDLE) || ((state_ff == S_OUT) && slot_free));
   assign job_pop   = start;
   assign rd_addr   = start ? WAW'(job_data.first_word) : word_ff;

   // word modify
   assign is_first = (word_ff == WAW'(cur_ff.first_word));
   assign is_last  = (word_ff == WAW'(cur_ff.last_word));
   assign req_op   = (cur_ff.opcode == pfba_pkg::OP_REQUEST);

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         mask[b] = !cur_ff.empty
                && (!is_first || (pfba_pkg::OFF_W'(b) >= cur_ff.first_off))
                && (!is_last  || (pfba_pkg::OFF_W'(b) <= cur_ff.last_off));
      end
   end

   assign cand  = mask & ~rd_data_ff;
   assign low   = cand & (~cand + MAP_WORD_BITS'(1));
   assign found = |cand;

   always_comb begin
      low_idx = '0;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         if (low[b]) begin
            low_idx = low_idx | BW'(b);
         end
      end
   end

   always_comb begin
      case (cur_ff.opcode)
         pfba_pkg::OP_LOCK, pfba_pkg::OP_RESERVE: begin
            change   = cand;
            new_word = rd_data_ff | cand;
         end
         pfba_pkg::OP_FREE, pfba_pkg::OP_UNRESERVE, pfba_pkg::OP_INIT: begin
            change   = mask & rd_data_ff;
            new_word = rd_data_ff & ~(mask & rd_data_ff);
         end
         pfba_pkg::OP_REQUEST: begin
            change   = low;
            new_word = rd_data_ff | low;
         end
         default: begin
            change   = '0;
            new_word = rd_data_ff;
         end
      endcase
   end

   assign n_changed = NW'($countones(change));
   assign page_idx  = PIW'(word_ff) * PIW'(MAP_WORD_BITS) + PIW'(low_idx);
   assign done      = cur_ff.empty || is_last || (req_op && found);

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = word_ff;
      wr_data = new_word;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == S_MODIFY) begin
         wr_en   = !cur_ff.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      changed_in   = changed_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      free_in      = free_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + WAW'(1);
            if (clr_ff == WAW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE, S_OUT: begin
            if ((state_ff == S_OUT) && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status:         status_ff,
                                granted_page:   granted_ff,
                                pages_changed:  changed_ff,
                                free_pages:     free_ff,
                                used_pages:     used_ff,
                                reserved_pages: res_ff};
               state_in     = S_IDLE;
            end
            if (start) begin
               cur_in     = job_data;
               word_in    = WAW'(job_data.first_word);
               changed_in = '0;
               status_in  = job_data.status;
               granted_in = '0;
               state_in   = S_MODIFY;
            end
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            changed_in = changed_ff + pfba_pkg::CNT_W'(n_changed);
            case (cur_ff.opcode)
               pfba_pkg::OP_LOCK, pfba_pkg::OP_REQUEST: begin
                  free_in = sat_sub(free_ff, n_changed);
                  used_in = sat_add(used_ff, n_changed);
               end
               pfba_pkg::OP_FREE: begin
                  free_in = sat_add(free_ff, n_changed);
                  used_in = sat_sub(used_ff, n_changed);
               end
               pfba_pkg::OP_RESERVE: begin
                  free_in = sat_sub(free_ff, n_changed);
                  res_in  = sat_add(res_ff, n_changed);
               end
               pfba_pkg::OP_UNRESERVE: begin
                  free_in = sat_add(free_ff, n_changed);
                  res_in  = sat_sub(res_ff, n_changed);
               end
               pfba_pkg::OP_INIT: begin
                  if (done) begin
                     free_in = size;
                     used_in = '0;
                     res_in  = '0;
                  end
               end
               default: begin
                  free_in = free_ff;
               end
            endcase
            if (done) begin
               if (req_op && !cur_ff.empty) begin
                  if (found) begin
                     granted_in = pfba_pkg::PAGE_W'(page_idx);
                  end else begin
                     status_in = pfba_pkg::STAT_NOFREE;
                  end
               end
               state_in = S_OUT;
            end else begin
               word_in  = word_ff + WAW'(1);
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= FREE_RESET;
         used_ff      <= '0;
         res_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         res_ff       <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      cur_ff      <= cur_in;
      changed_ff  <= changed_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/page_frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// Bitmap page frame allocator with free, used and reserved page counters.
//
// Requests enter on req_valid/req_ready as one req_type word (opcode, first
// page, page count); each gives exactly one rsp_type word on
// rsp_valid/rsp_ready, in order. total_pages is written over the APB port
// at address 0; the user must write it only while the block is idle, which
// the block itself does not enforce. A front end of two register stages
// clips the run and finds its first and last map word, a two-entry queue
// follows, and the map engine does the read-modify-write of one
// MAP_WORD_BITS wide map word at a time. The front end takes new requests
// while the engine works on earlier ones, and the engine can start the next
// job as it registers the response of the last. A run is worked over every
// map word it spans, a request over each word searched until a free page
// is found, init over all MAP_WORDS words.
// After reset the engine writes zero to every map word, MAP_WORDS of them
// (1024 at the defaults); requests queue up meanwhile, configuration writes
// are taken. A stalled response holds in its output register while the
// next item is worked on up to the point of its own result.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core #(
   parameter int MAX_PAGES     = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfba_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [pfba_pkg::CNT_W-1:0] total_pages_ff;
   logic [pfba_pkg::CNT_W-1:0] size;
   logic                       job_push, job_full, job_pop, job_valid;
   pfba_pkg::job_type          push_job, pop_job;

   assign pready = 1'b1;
   assign prdata = 32'(total_pages_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff <= pfba_pkg::CNT_W'(65536);
      end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
         total_pages_ff <= pwdata[pfba_pkg::CNT_W-1:0];
      end
   end

   assign size = (32'(total_pages_ff) > MAX_PAGES) ? pfba_pkg::CNT_W'(MAX_PAGES)
                                                   : total_pages_ff;

   pfba_front #(
      .MAX_PAGES     (MAX_PAGES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .size      (size),
      .job_push  (job_push),
      .job_full  (job_full),
      .job_data  (push_job)
   );

   pfba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .not_empty (job_valid)
   );

   pfba_back #(
      .MAX_PAGES     (MAX_PAGES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (pop_job),
      .job_pop   (job_pop),
      .size      (size),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == pfba_pkg::STAT_OK)
                 || (rsp_data.status == pfba_pkg::STAT_RANGE)
                 || (rsp_data.status == pfba_pkg::STAT_NOFREE))
      else $error("response status code out of set");

   a_nofree_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == pfba_pkg::STAT_NOFREE)
      |-> (rsp_data.granted_page == '0) && (rsp_data.pages_changed == '0))
      else $error("failed request reports a grant or a change");

   a_grant_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.granted_page != '0)
      |-> (rsp_data.status == pfba_pkg::STAT_OK)
       && (rsp_data.pages_changed == pfba_pkg::CNT_W'(1)))
      else $error("grant without exactly one page locked");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_push)
      else $error("job pushed into full queue");

endmodule

FILE: test/tb_page_frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_page_frame_bitmap_allocator_core
// Self-checking bench for the page frame bitmap allocator core. A clocked
// driver sends request words from a queue filled by the stimulus block, a
// clocked monitor checks each response word field by field against a
// bit-exact software copy of the page map and its counters. total_pages is
// rewritten over the APB port between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_page_frame_bitmap_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_FRAMES = 65536;
   localparam int unsigned MAP_WORDS  = 1024;
   localparam logic [pfba_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [pfba_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam logic [1:0] CSR_TOTAL_PAGES = 2'd0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pfba_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pfba_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [1:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   page_frame_bitmap_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // software copy of the allocator state
   bit [MAX_FRAMES-1:0] frame_map = '0;
   int unsigned free_cnt = MAX_FRAMES;
   int unsigned used_cnt = 0;
   int unsigned rsvd_cnt = 0;
   int unsigned total_pages_cfg = MAX_FRAMES;

   pfba_pkg::req_type page_ops_to_send[$];
   pfba_pkg::rsp_type page_op_replies[$];
   int unsigned ops_queued = 0;
   int unsigned ops_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned error_count = 0;
   longint unsigned cycle_count = 0;
   longint unsigned cycle_limit = 20000;
   int unsigned send_gap = 0;
   int unsigned send_burst = 0;
   int unsigned stall_left = 0;
   int unsigned stall_burst = 0;

   function automatic int unsigned sat_inc(int unsigned c);
      return (c < pfba_pkg::CNT_MAX) ? c + 1 : c;
   endfunction

   function automatic int unsigned sat_dec(int unsigned c);
      return (c > 0) ? c - 1 : c;
   endfunction

   function automatic pfba_pkg::rsp_type apply_page_op(pfba_pkg::req_type op_word);
      pfba_pkg::rsp_type res;
      int unsigned size;
      int unsigned p;
      int unsigned i;
      int unsigned changed;
      logic [pfba_pkg::STAT_W-1:0] stat;
      bit set_bit;
      bit to_used;
      bit found;
      size = (total_pages_cfg > MAX_FRAMES) ? MAX_FRAMES : total_pages_cfg;
      stat = pfba_pkg::STAT_OK;
      changed = 0;
      p = 0;
      found = 0;
      res = '0;
      case (op_word.opcode)
         pfba_pkg::OP_INIT: begin
            changed = $countones(frame_map);
            frame_map = '0;
            free_cnt = size;
            used_cnt = 0;
            rsvd_cnt = 0;
         end
         pfba_pkg::OP_LOCK, pfba_pkg::OP_FREE,
         pfba_pkg::OP_RESERVE, pfba_pkg::OP_UNRESERVE: begin
            set_bit = (op_word.opcode == pfba_pkg::OP_LOCK)
                   || (op_word.opcode == pfba_pkg::OP_RESERVE);
            to_used = (op_word.opcode == pfba_pkg::OP_LOCK)
                   || (op_word.opcode == pfba_pkg::OP_FREE);
            for (i = 0; i < op_word.page_count; i++) begin
               p = op_word.first_page + i;
               if (p >= size) begin
                  stat = pfba_pkg::STAT_RANGE;
                  continue;
               end
               if (frame_map[p] == set_bit) continue;
               frame_map[p] = set_bit;
               changed++;
               if (set_bit) begin
                  free_cnt = sat_dec(free_cnt);
                  if (to_used) used_cnt = sat_inc(used_cnt);
                  else rsvd_cnt = sat_inc(rsvd_cnt);
               end else begin
                  free_cnt = sat_inc(free_cnt);
                  if (to_used) used_cnt = sat_dec(used_cnt);
                  else rsvd_cnt = sat_dec(rsvd_cnt);
               end
            end
         end
         pfba_pkg::OP_REQUEST: begin
            for (p = 1; p < size; p++) begin
               if (!frame_map[p]) begin
                  found = 1;
                  break;
               end
            end
            if (found) begin
               frame_map[p] = 1'b1;
               free_cnt = sat_dec(free_cnt);
               used_cnt = sat_inc(used_cnt);
               res.granted_page = p[pfba_pkg::PAGE_W-1:0];
               changed = 1;
            end else begin
               stat = pfba_pkg::STAT_NOFREE;
            end
         end
         default: ;
      endcase
      res.status = stat;
      res.pages_changed = changed[pfba_pkg::CNT_W-1:0];
      res.free_pages = free_cnt[pfba_pkg::CNT_W-1:0];
      res.used_pages = used_cnt[pfba_pkg::CNT_W-1:0];
      res.reserved_pages = rsvd_cnt[pfba_pkg::CNT_W-1:0];
      return res;
   endfunction

   // mostly short gaps, a few long ones, and runs with none at all
   function automatic int unsigned idle_len(inout int unsigned burst);
      int unsigned r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void queue_op(logic [pfba_pkg::OP_W-1:0] opcode, int unsigned first,
                                    int unsigned count);
      pfba_pkg::req_type w;
      int unsigned words;
      w.opcode = opcode;
      w.first_page = first[pfba_pkg::PAGE_W-1:0];
      w.page_count = count[pfba_pkg::CNT_W-1:0];
      page_ops_to_send.push_back(w);
      ops_queued++;
      if (opcode == pfba_pkg::OP_INIT || opcode == pfba_pkg::OP_REQUEST) words = MAP_WORDS + 1;
      else words = ((w.page_count > MAX_FRAMES) ? MAX_FRAMES : w.page_count) / 64 + 2;
      cycle_limit += 4 * (2 * words + 100);
   endfunction

   task automatic wait_idle();
      while (!(ops_accepted == ops_queued && page_op_replies.size() == 0))
         @(posedge clock);
   endtask

   task automatic csr_write_total(int unsigned value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_TOTAL_PAGES;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      total_pages_cfg = value & 32'h1FFFF;
   endtask

   task automatic queue_random_op();
      int unsigned size;
      int unsigned r;
      int unsigned first;
      int unsigned count;
      logic [pfba_pkg::OP_W-1:0] opcode;
      size = (total_pages_cfg > MAX_FRAMES) ? MAX_FRAMES : total_pages_cfg;
      r = $urandom_range(0, 99);
      if (r < 3) opcode = pfba_pkg::OP_INIT;
      else if (r < 28) opcode = pfba_pkg::OP_LOCK;
      else if (r < 48) opcode = pfba_pkg::OP_FREE;
      else if (r < 63) opcode = pfba_pkg::OP_RESERVE;
      else if (r < 75) opcode = pfba_pkg::OP_UNRESERVE;
      else if (r < 98) opcode = pfba_pkg::OP_REQUEST;
      else if (r < 99) opcode = OP_SPARE_6;
      else opcode = OP_SPARE_7;
      r = $urandom_range(0, 99);
      if (r < 75) first = $urandom_range(0, (size < 65535) ? size : 65535);
      else if (r < 85) first = 65535 - $urandom_range(0, 15);
      else first = $urandom_range(0, 65535);
      r = $urandom_range(0, 99);
      if (r < 55) count = $urandom_range(0, 8);
      else if (r < 85) count = $urandom_range(1, 64);
      else if (r < 97) count = $urandom_range(1, 600);
      else count = $urandom_range(0, 131071);
      queue_op(opcode, first, count);
   endtask

   // driver
   always @(posedge clock) begin
      logic keep;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         keep = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            page_op_replies.push_back(apply_page_op(req_data));
            ops_accepted++;
         end
         if (!keep) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (page_ops_to_send.size() > 0) begin
               req_data <= page_ops_to_send.pop_front();
               keep = 1'b1;
               send_gap = idle_len(send_burst);
            end
         end
         req_valid <= keep;
      end
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      pfba_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (page_op_replies.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response word %h", $realtime, rsp_data);
            end else begin
               want = page_op_replies.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("granted_page", want.granted_page, rsp_data.granted_page);
               compare_field("pages_changed", want.pages_changed, rsp_data.pages_changed);
               compare_field("free_pages", want.free_pages, rsp_data.free_pages);
               compare_field("used_pages", want.used_pages, rsp_data.used_pages);
               compare_field("reserved_pages", want.reserved_pages,
                             rsp_data.reserved_pages);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = idle_len(stall_burst);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("tb_page_frame_bitmap_allocator_core: errors");
         $finish;
      end
   end

   initial begin
      int unsigned phase_sizes[9] = '{200, 1, 0, 131071, 64, 1000, 65536, 130, 65};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed
      queue_op(pfba_pkg::OP_REQUEST, 0, 0);
      queue_op(pfba_pkg::OP_LOCK, 0, 1);
      queue_op(pfba_pkg::OP_LOCK, 0, 0);
      queue_op(pfba_pkg::OP_RESERVE, 65535, 1);
      queue_op(pfba_pkg::OP_RESERVE, 65534, 3);
      queue_op(pfba_pkg::OP_LOCK, 100, 200);
      queue_op(pfba_pkg::OP_FREE, 150, 10);
      queue_op(pfba_pkg::OP_UNRESERVE, 100, 5);
      queue_op(pfba_pkg::OP_FREE, 65535, 1);
      queue_op(OP_SPARE_6, $urandom_range(0, 65535), $urandom_range(0, 131071));
      queue_op(OP_SPARE_7, 65535, 131071);
      queue_op(pfba_pkg::OP_LOCK, 0, 131071);
      queue_op(pfba_pkg::OP_REQUEST, 0, 0);
      queue_op(pfba_pkg::OP_UNRESERVE, 0, 65536);
      queue_op(pfba_pkg::OP_LOCK, 0, 65536);
      queue_op(pfba_pkg::OP_INIT, 0, 0);
      queue_op(pfba_pkg::OP_RESERVE, 40000, 25536);
      queue_op(pfba_pkg::OP_FREE, 0, 65536);
      queue_op(pfba_pkg::OP_REQUEST, 0, 0);
      queue_op(pfba_pkg::OP_LOCK, 65535, 1);
      queue_op(pfba_pkg::OP_REQUEST, 0, 0);
      queue_op(pfba_pkg::OP_INIT, 0, 0);

      foreach (phase_sizes[k]) begin
         wait_idle();
         repeat (20) @(posedge clock);
         csr_write_total(phase_sizes[k]);
         queue_op(pfba_pkg::OP_INIT, 0, 0);
         repeat (221) queue_random_op();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_page_frame_bitmap_allocator_core: clean");
      end else begin
         $display("tb_page_frame_bitmap_allocator_core: errors");
      end
      $finish;
   end

endmodule
